@@ sv/itl_pkg.sv @@
// Shared types, token codes and byte classification for the token lexer.
package itl_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [4:0] K_EOF      = 5'd0;
   localparam logic [4:0] K_PERIOD   = 5'd1;
   localparam logic [4:0] K_COMMA    = 5'd2;
   localparam logic [4:0] K_LPAREN   = 5'd3;
   localparam logic [4:0] K_RPAREN   = 5'd4;
   localparam logic [4:0] K_LBRACE   = 5'd5;
   localparam logic [4:0] K_RBRACE   = 5'd6;
   localparam logic [4:0] K_LBRACKET = 5'd7;
   localparam logic [4:0] K_RBRACKET = 5'd8;
   localparam logic [4:0] K_COLON    = 5'd9;
   localparam logic [4:0] K_DBLCOLON = 5'd10;
   localparam logic [4:0] K_COLONEQ  = 5'd11;
   localparam logic [4:0] K_TERM     = 5'd12;
   localparam logic [4:0] K_STRING   = 5'd13;
   localparam logic [4:0] K_NUMBER   = 5'd14;
   localparam logic [4:0] K_TYPENAME = 5'd15;
   localparam logic [4:0] K_NAME     = 5'd16;
   localparam logic [4:0] K_ERROR    = 5'd17;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FFEED   = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_PERIOD  = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   typedef enum logic [7:0] {
      MODE_IDLE      = 8'b0000_0001,
      MODE_COLON     = 8'b0000_0010,
      MODE_SPACE     = 8'b0000_0100,
      MODE_STRING    = 8'b0000_1000,
      MODE_NUMBER    = 8'b0001_0000,
      MODE_NUMBER_PT = 8'b0010_0000,
      MODE_TYPENAME  = 8'b0100_0000,
      MODE_NAME      = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [7:0]  content_byte;
      logic        byte_valid;
      logic        token_last;
      logic [15:0] indent_count;
      logic [15:0] start_line;
      logic [15:0] start_column;
   } rec_type;

   typedef struct packed {
      logic       ended;
      logic [1:0] push_n;
   } core_stat_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } fifo_stat_type;

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
             c == CH_FFEED || c == CH_CR;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_name(input logic [7:0] c);
      return !is_space(c) && c != CH_LPAREN && c != CH_RPAREN && c != CH_LBRACK &&
             c != CH_RBRACK && c != CH_LBRACE && c != CH_RBRACE && c != CH_COMMA &&
             c != CH_PERIOD && c != CH_DQUOTE;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         CH_PERIOD: k = K_PERIOD;
         CH_COMMA:  k = K_COMMA;
         CH_LPAREN: k = K_LPAREN;
         CH_RPAREN: k = K_RPAREN;
         CH_LBRACE: k = K_LBRACE;
         CH_RBRACE: k = K_RBRACE;
         CH_LBRACK: k = K_LBRACKET;
         CH_RBRACK: k = K_RBRACKET;
         default:   k = K_EOF;
      endcase
      return k;
   endfunction

endpackage

@@ sv/itl_if.sv @@
// Handshake channel interfaces for source bytes and token records.
interface itl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface itl_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [7:0]  content_byte;
   logic        byte_valid;
   logic        token_last;
   logic [15:0] indent_count;
   logic [15:0] start_line;
   logic [15:0] start_column;

   modport source (output valid, output token_kind, output content_byte,
                   output byte_valid, output token_last, output indent_count,
                   output start_line, output start_column, input ready);
   modport sink   (input valid, input token_kind, input content_byte,
                   input byte_valid, input token_last, input indent_count,
                   input start_line, input start_column, output ready);
endinterface

@@ sv/indent_aware_token_lexer.sv @@
// Top level of the indentation-aware token lexer.
//
//   channel   dir  payload                                        accepted when
//   req_chan  in   char_byte, end_of_input                        valid && ready
//   rsp_chan  out  token_kind, content_byte, byte_valid,          valid && ready
//                  token_last, indent_count, start_line, start_column
//
// One item per cycle: the step logic lexes the byte in the cycle it is taken
// and writes zero, one or two records into a four-entry result queue.
// Records come out one per cycle while rsp ready is high.
// req ready drops while fewer than two queue entries are free.
// Synchronous reset empties the queue and returns the lexer to line 1, column 0.
module indent_aware_token_lexer #(
   parameter int COUNTER_WIDTH = 16
) (
   input logic      clock,
   input logic      reset,
   itl_req_if.sink  req_chan,
   itl_rsp_if.source rsp_chan
);
   import itl_pkg::*;

   rec_type        rec0, rec1, head;
   core_stat_type  cstat;
   fifo_stat_type  fstat;
   logic           accept;

   assign req_chan.ready = fstat.count <= CNT_W'(FIFO_DEPTH - 2);
   assign accept         = req_chan.valid && req_chan.ready;

   itl_core #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_byte    (req_chan.char_byte),
      .end_of_input (req_chan.end_of_input),
      .rec0         (rec0),
      .rec1         (rec1),
      .stat         (cstat)
   );

   itl_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_n (cstat.push_n),
      .d0     (rec0),
      .d1     (rec1),
      .pop    (rsp_chan.ready),
      .head   (head),
      .stat   (fstat)
   );

   assign rsp_chan.valid        = fstat.count != '0;
   assign rsp_chan.token_kind   = head.token_kind;
   assign rsp_chan.content_byte = head.content_byte;
   assign rsp_chan.byte_valid   = head.byte_valid;
   assign rsp_chan.token_last   = head.token_last;
   assign rsp_chan.indent_count = head.indent_count;
   assign rsp_chan.start_line   = head.start_line;
   assign rsp_chan.start_column = head.start_column;

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (accept && cstat.push_n != 2'd0) |=> rsp_chan.valid)
      else $error("pushed record not visible");

   a_after_end: assert property (@(posedge clock) disable iff (reset)
      (accept && cstat.ended) |-> cstat.push_n == 2'd1)
      else $error("item after end must give one record");

   a_end_sticks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_input) |=> cstat.ended)
      else $error("end mark not recorded");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fstat.count <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

endmodule

@@ sv/itl_core.sv @@
// Lexer state registers and the per-byte step that yields up to two records.
module itl_core #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            char_byte,
   input  logic                  end_of_input,
   output itl_pkg::rec_type      rec0,
   output itl_pkg::rec_type      rec1,
   output itl_pkg::core_stat_type stat
);
   import itl_pkg::*;

   localparam int CW = COUNTER_WIDTH;

   mode_type        mode_ff, mode_in;
   logic [CW-1:0]   run_ff, run_in;
   logic [CW-1:0]   stored_ff, stored_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [CW-1:0]   line_ff, line_in;
   logic [CW-1:0]   tsl_ff, tsl_in;
   logic [CW-1:0]   tsc_ff, tsc_in;
   logic            ended_ff, ended_in;

   function automatic logic [15:0] clamp16(input logic [CW-1:0] v);
      logic [CW+15:0] ext;
      ext = {16'd0, v};
      return (|ext[CW+15:16]) ? 16'hFFFF : ext[15:0];
   endfunction

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic rec_type mk_rec(input logic [4:0] kind, input logic [7:0] b,
                                      input logic bv, input logic last,
                                      input logic [15:0] ind, input logic [15:0] ln,
                                      input logic [15:0] cl);
      rec_type r;
      r.token_kind   = kind;
      r.content_byte = b;
      r.byte_valid   = bv;
      r.token_last   = last;
      r.indent_count = ind;
      r.start_line   = ln;
      r.start_column = cl;
      return r;
   endfunction

   logic            nl;
   logic [CW-1:0]   pos_line, pos_col;
   logic [15:0]     pl16, pc16, tl16, tc16;
   logic            term_v;
   rec_type         term_rec;
   mode_type        beg_mode;
   logic            beg_v, beg_do;
   rec_type         beg_rec;
   logic [4:0]      sk;
   logic            first_v, sec_v;
   rec_type         first, sec;

   always_comb begin
      nl       = char_byte == CH_NEWLINE;
      pos_line = nl ? sat_inc(line_ff) : line_ff;
      pos_col  = nl ? '0 : sat_inc(col_ff);
      pl16     = clamp16(pos_line);
      pc16     = clamp16(pos_col);
      tl16     = clamp16(tsl_ff);
      tc16     = clamp16(tsc_ff);
      term_v   = run_ff <= stored_ff;
      term_rec = mk_rec(K_TERM, 8'd0, 1'b0, 1'b1, clamp16(run_ff), tl16, tc16);

      // token started by this byte
      sk       = single_kind(char_byte);
      beg_v    = 1'b0;
      beg_rec  = mk_rec(K_EOF, 8'd0, 1'b0, 1'b1, 16'd0, pl16, pc16);
      if (sk != K_EOF) begin
         beg_mode = MODE_IDLE;
         beg_v    = 1'b1;
         beg_rec  = mk_rec(sk, 8'd0, 1'b0, 1'b1, 16'd0, pl16, pc16);
      end else if (char_byte == CH_COLON) begin
         beg_mode = MODE_COLON;
      end else if (is_space(char_byte)) begin
         beg_mode = MODE_SPACE;
      end else if (char_byte == CH_DQUOTE) begin
         beg_mode = MODE_STRING;
      end else if (is_digit(char_byte)) begin
         beg_mode = MODE_NUMBER;
         beg_v    = 1'b1;
         beg_rec  = mk_rec(K_NUMBER, char_byte, 1'b1, 1'b0, 16'd0, pl16, pc16);
      end else if (char_byte == CH_SQUOTE) begin
         beg_mode = MODE_TYPENAME;
      end else begin
         beg_mode = MODE_NAME;
         beg_v    = 1'b1;
         beg_rec  = mk_rec(K_NAME, char_byte, 1'b1, 1'b0, 16'd0, pl16, pc16);
      end

      mode_in   = mode_ff;
      run_in    = run_ff;
      stored_in = stored_ff;
      col_in    = col_ff;
      line_in   = line_ff;
      tsl_in    = tsl_ff;
      tsc_in    = tsc_ff;
      ended_in  = ended_ff;
      first_v   = 1'b0;
      first     = term_rec;
      sec_v     = 1'b0;
      sec       = mk_rec(K_EOF, 8'd0, 1'b0, 1'b1, 16'd0, clamp16(line_ff), clamp16(col_ff));
      beg_do    = 1'b0;

      if (ended_ff) begin
         sec_v = 1'b1;
      end else if (end_of_input) begin
         ended_in = 1'b1;
         mode_in  = MODE_IDLE;
         sec_v    = 1'b1;
         case (mode_ff)
            MODE_COLON: begin
               first_v = 1'b1;
               first   = mk_rec(K_COLON, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
            end
            MODE_SPACE: begin
               if (term_v) begin
                  first_v   = 1'b1;
                  stored_in = run_ff;
               end
            end
            MODE_STRING: begin
               first_v = 1'b1;
               first   = mk_rec(K_ERROR, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
            end
            MODE_NUMBER, MODE_NUMBER_PT: begin
               first_v = 1'b1;
               first   = mk_rec(K_NUMBER, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
            end
            MODE_TYPENAME: begin
               first_v = 1'b1;
               first   = mk_rec(K_TYPENAME, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
            end
            MODE_NAME: begin
               first_v = 1'b1;
               first   = mk_rec(K_NAME, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
            end
            default: begin
            end
         endcase
      end else begin
         line_in = pos_line;
         col_in  = pos_col;
         case (mode_ff)
            MODE_COLON: begin
               first_v = 1'b1;
               mode_in = MODE_IDLE;
               if (char_byte == CH_COLON) begin
                  first = mk_rec(K_DBLCOLON, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
               end else if (char_byte == CH_EQUALS) begin
                  first = mk_rec(K_COLONEQ, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
               end else begin
                  first  = mk_rec(K_COLON, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
                  beg_do = 1'b1;
               end
            end
            MODE_SPACE: begin
               if (is_space(char_byte)) begin
                  run_in = nl ? '0 : sat_inc(run_ff);
               end else begin
                  if (term_v) begin
                     first_v   = 1'b1;
                     stored_in = run_ff;
                  end
                  beg_do = 1'b1;
               end
            end
            MODE_STRING: begin
               first_v = 1'b1;
               if (char_byte == CH_DQUOTE) begin
                  first   = mk_rec(K_STRING, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
                  mode_in = MODE_IDLE;
               end else begin
                  first = mk_rec(K_STRING, char_byte, 1'b1, 1'b0, 16'd0, tl16, tc16);
               end
            end
            MODE_NUMBER, MODE_NUMBER_PT: begin
               first_v = 1'b1;
               if (is_digit(char_byte)) begin
                  first = mk_rec(K_NUMBER, char_byte, 1'b1, 1'b0, 16'd0, tl16, tc16);
               end else if (char_byte == CH_PERIOD && mode_ff == MODE_NUMBER) begin
                  first   = mk_rec(K_NUMBER, char_byte, 1'b1, 1'b0, 16'd0, tl16, tc16);
                  mode_in = MODE_NUMBER_PT;
               end else begin
                  first  = mk_rec(K_NUMBER, 8'd0, 1'b0, 1'b1, 16'd0, tl16, tc16);
                  beg_do = 1'b1;
               end
            end
            MODE_TYPENAME, MODE_NAME: begin
               first_v = 1'b1;
               if (is_name(char_byte)) begin
                  first = mk_rec((mode_ff == MODE_NAME) ? K_NAME : K_TYPENAME, char_byte,
                                 1'b1, 1'b0, 16'd0, tl16, tc16);
               end else begin
                  first  = mk_rec((mode_ff == MODE_NAME) ? K_NAME : K_TYPENAME, 8'd0,
                                  1'b0, 1'b1, 16'd0, tl16, tc16);
                  beg_do = 1'b1;
               end
            end
            default: begin
               beg_do = 1'b1;
            end
         endcase
         if (beg_do) begin
            mode_in = beg_mode;
            tsl_in  = pos_line;
            tsc_in  = pos_col;
            sec_v   = beg_v;
            sec     = beg_rec;
            if (beg_mode == MODE_SPACE) begin
               run_in = nl ? '0 : CW'(1);
            end
         end
      end

      rec0  = first_v ? first : sec;
      rec1  = sec;
      stat.ended  = ended_ff;
      stat.push_n = accept ? ({1'b0, first_v} + {1'b0, sec_v}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         run_ff    <= '0;
         stored_ff <= '0;
         col_ff    <= '0;
         line_ff   <= CW'(1);
         tsl_ff    <= '0;
         tsc_ff    <= '0;
         ended_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         run_ff    <= run_in;
         stored_ff <= stored_in;
         col_ff    <= col_in;
         line_ff   <= line_in;
         tsl_ff    <= tsl_in;
         tsc_ff    <= tsc_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

@@ sv/itl_fifo.sv @@
// Result queue taking up to two records per cycle and giving one per cycle while pop is high.
module itl_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_n,
   input  itl_pkg::rec_type      d0,
   input  itl_pkg::rec_type      d1,
   input  logic                  pop,
   output itl_pkg::rec_type      head,
   output itl_pkg::fifo_stat_type stat
);
   import itl_pkg::*;

   rec_type           mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   always_comb begin
      do_pop    = pop && count_ff != '0;
      wr_next   = wr_ff + PTR_W'(1);
      wr_in     = wr_ff + PTR_W'(push_n);
      rd_in     = rd_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(do_pop);
      head      = mem_ff[rd_ff];
      stat.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= d0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_next] <= d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
